@@ hw/rtl/nslog_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nslog_pkg
// shared constants, codes and types of the changed namespace list log
// ----------------------------------------------------------------------------
package nslog_pkg;

    localparam int CAPACITY    = 1024;
    localparam int MODE_W      = 2;
    localparam int NSID_W      = 32;
    localparam int WINDOW_W    = 16;
    localparam int RANK_W      = 10;
    localparam int POS_W       = 12;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int END_W       = WINDOW_W + 1;
    localparam int LIMIT_W     = 13;
    localparam int AT_W        = RANK_W + 2;
    localparam int RANKCMP_W   = RANK_W + 1;

    localparam logic [LIMIT_W-1:0] LOG_LIMIT   = LIMIT_W'(4096);
    localparam logic [END_W-1:0]   ENTRY_BYTES = END_W'(4);
    localparam logic [NSID_W-1:0]  NSID_EVERY  = '1;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

    // eight-way registered reduction tree over the cell row
    localparam int TREE_FANIN  = 8;
    localparam int TREE_LEVELS = (IDX_W + 2) / 3;
    localparam int TREE_LEAVES = 1 << (3 * TREE_LEVELS);
    localparam int WAIT_W      = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

    function automatic int tree_base(input int level);
        int b;
        b = 0;
        for (int m = 1; m < level; m++)
        begin
            b = b + (TREE_LEAVES >> (3 * m));
        end
        return b;
    endfunction

    localparam int TREE_NODES = tree_base(TREE_LEVELS + 1);

    typedef struct packed {
        logic              hit;
        logic [NSID_W-1:0] data;
    } node_t;

    typedef struct packed {
        logic [NSID_W-1:0]  nsid;
        logic [COUNT_W-1:0] count;
        logic [RANK_W-1:0]  rank;
        logic               insert;
    } cell_ctl_t;

endpackage

@@ hw/rtl/nslog_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nslog_req_if
// request channel: append, read or finish transaction
// ----------------------------------------------------------------------------
interface nslog_req_if;
    logic                             valid;
    logic                             ready;
    logic [nslog_pkg::MODE_W-1:0]     mode;
    logic [nslog_pkg::NSID_W-1:0]     nsid;
    logic [nslog_pkg::WINDOW_W-1:0]   window_offset;
    logic [nslog_pkg::WINDOW_W-1:0]   window_length;
    logic [nslog_pkg::RANK_W-1:0]     rank;

    modport source (output valid, mode, nsid, window_offset, window_length, rank,
                    input ready);
    modport sink (input valid, mode, nsid, window_offset, window_length, rank,
                  output ready);
endinterface

@@ hw/rtl/nslog_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nslog_rsp_if
// response channel: one transaction per request
// ----------------------------------------------------------------------------
interface nslog_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          write_enable;
    logic [nslog_pkg::POS_W-1:0]   byte_position;
    logic [nslog_pkg::NSID_W-1:0]  value;

    modport source (output valid, write_enable, byte_position, value, input ready);
    modport sink (input valid, write_enable, byte_position, value, output ready);
endinterface

@@ hw/rtl/nslog_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nslog_cell
// one slot of the sorted identifier row with compare, shift and select
// ----------------------------------------------------------------------------
module nslog_cell (
    input  logic                          clk,
    input  nslog_pkg::cell_ctl_t          ctl,
    input  logic [nslog_pkg::IDX_W-1:0]   idx,
    input  logic [nslog_pkg::NSID_W-1:0]  left_value,
    input  logic                          left_gt,
    output logic [nslog_pkg::NSID_W-1:0]  value,
    output logic                          gt,
    output nslog_pkg::node_t              leaf
);

    logic [nslog_pkg::NSID_W-1:0] value_reg;
    logic [nslog_pkg::NSID_W-1:0] value_next;
    logic                         occupied;
    logic                         sel;

    assign occupied = nslog_pkg::COUNT_W'(idx) < ctl.count;
    assign gt       = !occupied || (value_reg > ctl.nsid);
    assign sel      = nslog_pkg::RANK_W'(idx) == ctl.rank;
    assign value    = value_reg;

    assign leaf.hit  = occupied && (value_reg == ctl.nsid);
    assign leaf.data = sel ? value_reg : '0;

    // insert: first larger slot takes the new id, the rest shift right
    always_comb
    begin
        value_next = value_reg;
        if (ctl.insert && gt)
        begin
            value_next = left_gt ? left_value : ctl.nsid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ hw/rtl/nslog_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nslog_tree
// registered eight-way or-tree collecting match and selected entry
// ----------------------------------------------------------------------------
module nslog_tree (
    input  logic             clk,
    input  nslog_pkg::node_t leaves [nslog_pkg::TREE_LEAVES],
    output nslog_pkg::node_t root
);

    nslog_pkg::node_t tree_reg [nslog_pkg::TREE_NODES];

    for (genvar l = 1; l <= nslog_pkg::TREE_LEVELS; l++)
    begin : g_level
        localparam int NODES     = nslog_pkg::TREE_LEAVES >> (3 * l);
        localparam int BASE      = nslog_pkg::tree_base(l);
        localparam int PREV_BASE = nslog_pkg::tree_base(l - 1);
        for (genvar j = 0; j < NODES; j++)
        begin : g_node
            nslog_pkg::node_t node_next;

            if (l == 1)
            begin : g_first
                always_comb
                begin
                    node_next = '0;
                    for (int k = 0; k < nslog_pkg::TREE_FANIN; k++)
                    begin
                        node_next = nslog_pkg::node_t'(node_next
                            | leaves[nslog_pkg::TREE_FANIN * j + k]);
                    end
                end
            end
            else
            begin : g_upper
                always_comb
                begin
                    node_next = '0;
                    for (int k = 0; k < nslog_pkg::TREE_FANIN; k++)
                    begin
                        node_next = nslog_pkg::node_t'(node_next
                            | tree_reg[PREV_BASE + nslog_pkg::TREE_FANIN * j + k]);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                tree_reg[BASE + j] <= node_next;
            end
        end
    end

    assign root = tree_reg[nslog_pkg::TREE_NODES - 1];

endmodule

@@ hw/rtl/changed_namespace_list_log.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// changed_namespace_list_log
// sorted set of changed namespace ids with overflow and windowed readout
// ----------------------------------------------------------------------------
// The identifiers live in a row of cells, one per slot, kept in ascending
// order; an append shifts all larger entries one cell right together.
// Duplicate detection and rank selection are gathered from the row by a
// registered eight-way or-tree of TREE_LEVELS stages (4 at 1024 entries), so
// each request passes the wait state while the tree settles, then the apply
// state, where its response is registered once the output register is free,
// and a new request is taken only after the last one has left the apply
// state. A finished response waits in the output register while the next
// request is already accepted. No clearing pass after reset.
// ----------------------------------------------------------------------------
module changed_namespace_list_log (
    input  logic         clk,
    input  logic         rst_n,
    nslog_req_if.sink    request,
    nslog_rsp_if.source  response
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [nslog_pkg::WAIT_W-1:0]        wait_reg, wait_next;
    logic [nslog_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic                                overflow_reg, overflow_next;

    logic [nslog_pkg::MODE_W-1:0]        mode_reg;
    logic [nslog_pkg::NSID_W-1:0]        nsid_reg;
    logic [nslog_pkg::WINDOW_W-1:0]      offset_reg;
    logic [nslog_pkg::WINDOW_W-1:0]      length_reg;
    logic [nslog_pkg::RANK_W-1:0]        rank_reg;

    logic                                out_valid_reg, out_valid_next;
    logic                                we_reg, we_next;
    logic [nslog_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [nslog_pkg::NSID_W-1:0]        val_reg, val_next;

    logic                                accept;
    logic                                finish;
    logic                                insert;
    logic                                full;
    logic [nslog_pkg::END_W-1:0]         end_sum;
    logic [nslog_pkg::LIMIT_W-1:0]       end_clip;
    logic [nslog_pkg::AT_W-1:0]          at;

    nslog_pkg::cell_ctl_t                ctl;
    nslog_pkg::node_t                    leaves [nslog_pkg::TREE_LEAVES];
    nslog_pkg::node_t                    root;
    logic [nslog_pkg::NSID_W-1:0]        cell_value [nslog_pkg::CAPACITY];
    logic                                cell_gt    [nslog_pkg::CAPACITY];

    assign request.ready  = state_reg == ST_IDLE;
    assign accept         = request.valid && request.ready;
    assign finish         = (state_reg == ST_APPLY) && (!out_valid_reg || response.ready);

    assign response.valid         = out_valid_reg;
    assign response.write_enable  = we_reg;
    assign response.byte_position = pos_reg;
    assign response.value         = val_reg;

    assign full   = count_reg >= nslog_pkg::COUNT_W'(nslog_pkg::CAPACITY);
    assign insert = finish && (mode_reg == nslog_pkg::MODE_APPEND) && !overflow_reg
                    && !full && (nsid_reg != nslog_pkg::NSID_EVERY) && !root.hit;

    assign ctl.nsid   = nsid_reg;
    assign ctl.count  = count_reg;
    assign ctl.rank   = rank_reg;
    assign ctl.insert = insert;

    // cell row
    for (genvar i = 0; i < nslog_pkg::CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            nslog_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .idx        (nslog_pkg::IDX_W'(i)),
                .left_value ('0),
                .left_gt    (1'b0),
                .value      (cell_value[i]),
                .gt         (cell_gt[i]),
                .leaf       (leaves[i])
            );
        end
        else
        begin : g_body
            nslog_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .idx        (nslog_pkg::IDX_W'(i)),
                .left_value (cell_value[i-1]),
                .left_gt    (cell_gt[i-1]),
                .value      (cell_value[i]),
                .gt         (cell_gt[i]),
                .leaf       (leaves[i])
            );
        end
    end

    for (genvar i = nslog_pkg::CAPACITY; i < nslog_pkg::TREE_LEAVES; i++)
    begin : g_pad
        assign leaves[i] = '0;
    end

    nslog_tree u_tree (
        .clk    (clk),
        .leaves (leaves),
        .root   (root)
    );

    // read window arithmetic
    assign end_sum  = nslog_pkg::END_W'(offset_reg) + nslog_pkg::END_W'(length_reg);
    assign end_clip = (end_sum > nslog_pkg::END_W'(nslog_pkg::LOG_LIMIT))
                      ? nslog_pkg::LOG_LIMIT : nslog_pkg::LIMIT_W'(end_sum);
    assign at       = {rank_reg, 2'b00};

    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg;
        we_next        = we_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;

        if (out_valid_reg && response.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WAIT;
                    wait_next  = '0;
                end
            end
            ST_WAIT:
            begin
                wait_next = wait_reg + nslog_pkg::WAIT_W'(1);
                if (wait_reg == nslog_pkg::WAIT_W'(nslog_pkg::TREE_LEVELS - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    we_next        = 1'b0;
                    pos_next       = '0;
                    val_next       = '0;
                    case (mode_reg)
                        nslog_pkg::MODE_APPEND:
                        begin
                            if (nsid_reg == nslog_pkg::NSID_EVERY || full)
                            begin
                                overflow_next = 1'b1;
                                count_next    = '0;
                            end
                            else if (insert)
                            begin
                                count_next = count_reg + nslog_pkg::COUNT_W'(1);
                            end
                        end
                        nslog_pkg::MODE_READ:
                        begin
                            if (overflow_reg)
                            begin
                                if (rank_reg == '0 && offset_reg == '0
                                    && end_sum >= nslog_pkg::ENTRY_BYTES)
                                begin
                                    we_next  = 1'b1;
                                    val_next = nslog_pkg::NSID_EVERY;
                                end
                            end
                            else if (nslog_pkg::RANKCMP_W'(rank_reg)
                                         < nslog_pkg::RANKCMP_W'(count_reg)
                                     && nslog_pkg::LIMIT_W'(at) < end_clip
                                     && nslog_pkg::WINDOW_W'(at) >= offset_reg)
                            begin
                                we_next  = 1'b1;
                                pos_next = at - offset_reg[nslog_pkg::POS_W-1:0];
                                val_next = root.data;
                            end
                        end
                        nslog_pkg::MODE_FINISH:
                        begin
                            count_next    = '0;
                            overflow_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        we_reg  <= we_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        if (accept)
        begin
            mode_reg   <= request.mode;
            nsid_reg   <= request.nsid;
            offset_reg <= request.window_offset;
            length_reg <= request.window_length;
            rank_reg   <= request.rank;
        end
    end

endmodule
